// File: rtl/decimal_digit_tile_writer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decimal digit tile writer
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_DIGIT_TILE_WRITER_ASSERT_SVH
`define DECIMAL_DIGIT_TILE_WRITER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DDTW_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DDTW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/ddtw_pkg.sv
// ----------------------------------------------------------------------------
// Decimal digit tile writer package
// Types and constants shared by the controller, datapath and top level.
// ----------------------------------------------------------------------------
package ddtw_pkg;

   // Number of decimal digits of a 15-bit magnitude.
   localparam int unsigned DIGITS = 5;

   // Digit position of the ones digit; positions run from the most significant.
   localparam logic [2:0] LAST_POS = 3'd4;

   // Conversion counter marks: end of the column divide and end of conversion.
   localparam logic [3:0] CNT_DIV_END = 4'd7;
   localparam logic [3:0] CNT_LAST    = 4'd15;

   // Cursor value that wraps to zero on the next advance.
   localparam logic [7:0] CURSOR_MAX = 8'hFF;

   // Input commands.
   localparam logic CMD_PRINT = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   // Configuration register indexes.
   localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
   localparam logic [2:0] REG_AREA_WIDTH  = 3'd2;
   localparam logic [2:0] REG_AREA_HEIGHT = 3'd3;
   localparam logic [2:0] REG_TILE_BASE   = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_EMIT,
      ST_ERROR
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       start;
      logic       clear_cursor;
      logic       conv;
      logic       phase;
      logic       div_end1;
      logic       div_end2;
      logic       emit_digit;
      logic       emit_error;
      logic [2:0] digit_pos;
   } ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic       in_clear;
      logic       in_neg;
      logic       out_free;
      logic [2:0] lead_pos;
   } stat_type;

endpackage

// File: rtl/ddtw_if.sv
// ----------------------------------------------------------------------------
// Decimal digit tile writer channels
// Valid/ready channel interfaces for requests and tile write responses.
// ----------------------------------------------------------------------------
interface ddtw_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic signed [15:0] number;

   modport source (output valid, output cmd, output number, input ready);
   modport sink (input valid, input cmd, input number, output ready);
endinterface

interface ddtw_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tile_x;
   logic [7:0] tile_y;
   logic [7:0] tile_index;
   logic       negative_error;
   logic       last_digit;

   modport source (output valid, output tile_x, output tile_y, output tile_index,
                   output negative_error, output last_digit, input ready);
   modport sink (input valid, input tile_x, input tile_y, input tile_index,
                 input negative_error, input last_digit, output ready);
endinterface

// File: rtl/ddtw_ctrl.sv
// ----------------------------------------------------------------------------
// Decimal digit tile writer controller
// Sequences request intake, the 16-step conversion and the digit writes.
// ----------------------------------------------------------------------------
module ddtw_ctrl
   import ddtw_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output ctrl_type ctrl
);

   state_type  state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [2:0] pos_ff, pos_in;
   logic       take;

   assign take = req_valid && (state_ff == ST_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !stat.in_clear) begin
               state_in = stat.in_neg ? ST_ERROR : ST_CONV;
            end
         end
         ST_CONV: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.out_free && (pos_ff == LAST_POS)) begin
               state_in = ST_IDLE;
            end
         end
         ST_ERROR: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Step counter and digit position.
   always_comb begin
      cnt_in = (state_ff == ST_CONV) ? cnt_ff + 4'd1 : 4'd0;
      pos_in = pos_ff;
      if ((state_ff == ST_CONV) && (cnt_ff == CNT_LAST)) begin
         pos_in = stat.lead_pos;
      end else if ((state_ff == ST_EMIT) && stat.out_free) begin
         pos_in = pos_ff + 3'd1;
      end
   end

   // Commands to the datapath.
   always_comb begin
      req_ready         = (state_ff == ST_IDLE);
      ctrl              = '0;
      ctrl.digit_pos    = pos_ff;
      ctrl.phase        = cnt_ff[3];
      ctrl.start        = take && !stat.in_clear && !stat.in_neg;
      ctrl.clear_cursor = take && stat.in_clear;
      ctrl.conv         = (state_ff == ST_CONV);
      ctrl.div_end1     = (state_ff == ST_CONV) && (cnt_ff == CNT_DIV_END);
      ctrl.div_end2     = (state_ff == ST_CONV) && (cnt_ff == CNT_LAST);
      ctrl.emit_digit   = (state_ff == ST_EMIT) && stat.out_free;
      ctrl.emit_error   = (state_ff == ST_ERROR) && stat.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= 4'd0;
         pos_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

// File: rtl/ddtw_datapath.sv
// ----------------------------------------------------------------------------
// Decimal digit tile writer datapath
// Configuration registers, cursor, shift-add-3 BCD converter, shared restoring
// divider for the cursor position, and the response register.
// ----------------------------------------------------------------------------
`include "decimal_digit_tile_writer_assert.svh"

module ddtw_datapath
   import ddtw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [7:0]         csr_wdata,
   input  logic               req_cmd,
   input  logic signed [15:0] req_number,
   input  ctrl_type           ctrl,
   output stat_type           stat,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_tile_x,
   output logic [7:0]         rsp_tile_y,
   output logic [7:0]         rsp_tile_index,
   output logic               rsp_negative_error,
   output logic               rsp_last_digit
);

   logic [7:0]  origin_x_ff, origin_y_ff, area_width_ff, area_height_ff, tile_base_ff;
   logic [7:0]  cursor_ff, cursor_in;
   logic [15:0] bin_ff, bin_in;
   logic [19:0] bcd_ff, bcd_in, bcd_adj;
   logic [7:0]  rem_ff, quo_ff, col_ff, yo_ff;
   logic [7:0]  rem_next, quo_next, col_in, yo_in;
   logic [8:0]  w_eff, h_eff, divisor, trial, diff, col_inc, yo_inc;
   logic        ge;
   logic [3:0]  digit_arr [DIGITS];
   logic [3:0]  next_arr [DIGITS];
   logic [2:0]  lead;
   logic        out_free;
   logic        rsp_valid_ff;
   logic [7:0]  tile_x_ff, tile_y_ff, tile_index_ff;
   logic        neg_ff, last_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff    <= 8'd0;
         origin_y_ff    <= 8'd0;
         area_width_ff  <= 8'd1;
         area_height_ff <= 8'd1;
         tile_base_ff   <= 8'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ORIGIN_X:    origin_x_ff    <= csr_wdata;
            REG_ORIGIN_Y:    origin_y_ff    <= csr_wdata;
            REG_AREA_WIDTH:  area_width_ff  <= csr_wdata;
            REG_AREA_HEIGHT: area_height_ff <= csr_wdata;
            REG_TILE_BASE:   tile_base_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A zero width or height stands for 256.
   assign w_eff = (area_width_ff == 8'd0) ? 9'd256 : {1'b0, area_width_ff};
   assign h_eff = (area_height_ff == 8'd0) ? 9'd256 : {1'b0, area_height_ff};

   // One shift-add-3 step of the binary to BCD conversion.
   always_comb begin
      bcd_adj = bcd_ff;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (ctrl.start) begin
         bin_in = req_number;
         bcd_in = '0;
      end else if (ctrl.conv) begin
         bin_in = {bin_ff[14:0], 1'b0};
         bcd_in = {bcd_adj[18:0], bin_ff[15]};
      end
   end

   // Digits by position, most significant first, now and after this step.
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         digit_arr[i] = bcd_ff[(DIGITS - 1 - i)*4 +: 4];
         next_arr[i]  = bcd_in[(DIGITS - 1 - i)*4 +: 4];
      end
   end

   // Leading nonzero digit of the finished conversion; a zero keeps the ones.
   always_comb begin
      lead = LAST_POS;
      for (int i = DIGITS - 1; i >= 0; i--) begin
         if (next_arr[i] != 4'd0) begin
            lead = 3'(i);
         end
      end
   end

   // Restoring divider step: cursor by width, then row by height.
   assign divisor  = ctrl.phase ? h_eff : w_eff;
   assign trial    = {rem_ff, quo_ff[7]};
   assign ge       = (trial >= divisor);
   assign diff     = trial - divisor;
   assign rem_next = ge ? diff[7:0] : trial[7:0];
   assign quo_next = {quo_ff[6:0], ge};

   // Position advance that follows the cursor by one.
   assign col_inc = {1'b0, col_ff} + 9'd1;
   assign yo_inc  = {1'b0, yo_ff} + 9'd1;

   always_comb begin
      col_in    = col_ff;
      yo_in     = yo_ff;
      cursor_in = cursor_ff;
      if (ctrl.clear_cursor) begin
         cursor_in = 8'd0;
      end else if (ctrl.conv) begin
         if (ctrl.div_end1) begin
            col_in = rem_next;
         end
         if (ctrl.div_end2) begin
            yo_in = rem_next;
         end
      end else if (ctrl.emit_digit) begin
         cursor_in = cursor_ff + 8'd1;
         priority if (cursor_ff == CURSOR_MAX) begin
            col_in = 8'd0;
            yo_in  = 8'd0;
         end else if (col_inc == w_eff) begin
            col_in = 8'd0;
            yo_in  = (yo_inc == h_eff) ? 8'd0 : yo_inc[7:0];
         end else begin
            col_in = col_inc[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= 8'd0;
         col_ff    <= 8'd0;
         yo_ff     <= 8'd0;
      end else begin
         cursor_ff <= cursor_in;
         col_ff    <= col_in;
         yo_ff     <= yo_in;
      end
   end

   // Conversion and divider registers.
   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      if (ctrl.start) begin
         rem_ff <= 8'd0;
         quo_ff <= cursor_ff;
      end else if (ctrl.conv) begin
         rem_ff <= ctrl.div_end1 ? 8'd0 : rem_next;
         quo_ff <= quo_next;
      end
   end

   // Response register; it frees up as soon as the transaction completes.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.emit_digit || ctrl.emit_error) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit_digit) begin
         tile_x_ff     <= origin_x_ff + col_ff;
         tile_y_ff     <= origin_y_ff + yo_ff;
         tile_index_ff <= {4'd0, digit_arr[ctrl.digit_pos]} + tile_base_ff;
         neg_ff        <= 1'b0;
         last_ff       <= (ctrl.digit_pos == LAST_POS);
      end else if (ctrl.emit_error) begin
         tile_x_ff     <= 8'd0;
         tile_y_ff     <= 8'd0;
         tile_index_ff <= 8'd0;
         neg_ff        <= 1'b1;
         last_ff       <= 1'b1;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_tile_x         = tile_x_ff;
   assign rsp_tile_y         = tile_y_ff;
   assign rsp_tile_index     = tile_index_ff;
   assign rsp_negative_error = neg_ff;
   assign rsp_last_digit     = last_ff;

   assign stat.in_clear = (req_cmd == CMD_CLEAR);
   assign stat.in_neg   = req_number[15];
   assign stat.out_free = out_free;
   assign stat.lead_pos = lead;

   // Each digit write moves the cursor on by exactly one.
   `DDTW_ASSERT_NEXT(a_cursor_step, ctrl.emit_digit, cursor_ff == $past(cursor_ff) + 8'd1, "cursor did not advance")
   // An error response is presented with its flags and a zero tile index.
   `DDTW_ASSERT_NEXT(a_error_rsp, ctrl.emit_error, rsp_valid && rsp_negative_error && rsp_last_digit && (rsp_tile_index == 8'd0), "bad error response")
   // A digit write is presented without the error flag.
   `DDTW_ASSERT_NEXT(a_digit_rsp, ctrl.emit_digit, rsp_valid && !rsp_negative_error, "bad digit response")

endmodule

// File: rtl/decimal_digit_tile_writer.sv
// ----------------------------------------------------------------------------
// Decimal digit tile writer
// A print request is taken at intake, then runs the 16 steps of the shift-add-3
// BCD converter, which also run the 8-step divides of the cursor by the area
// width and of the row by the area height, then writes one digit per cycle while
// the response side keeps up, 1 to 5 digits. A negative number is answered with
// a single error write, and a cursor clear is taken without any write. The
// response register lets the last write wait while the next request is taken.
// Position and tile come from the five 8-bit registers at indexes 0 to 4; write
// them only while the block is idle.
// ----------------------------------------------------------------------------
module decimal_digit_tile_writer
   import ddtw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   ddtw_req_if.sink   req_bus,
   ddtw_rsp_if.source rsp_bus,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);

   ctrl_type ctrl;
   stat_type stat;

   // Sequencing.
   ddtw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   // Arithmetic and storage.
   ddtw_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_cmd            (req_bus.cmd),
      .req_number         (req_bus.number),
      .ctrl               (ctrl),
      .stat               (stat),
      .rsp_valid          (rsp_bus.valid),
      .rsp_ready          (rsp_bus.ready),
      .rsp_tile_x         (rsp_bus.tile_x),
      .rsp_tile_y         (rsp_bus.tile_y),
      .rsp_tile_index     (rsp_bus.tile_index),
      .rsp_negative_error (rsp_bus.negative_error),
      .rsp_last_digit     (rsp_bus.last_digit)
   );

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Decimal digit tile writer testbench
// Drives print and cursor clear requests into the tile writer in directed runs and
// random bursts while the response side stalls on its own pattern. A scoreboard predicts
// every tile write from its own copy of the cursor and the area registers and
// checks each response field by field. Register settings change between
// phases, only when the block is idle.
// ----------------------------------------------------------------------------
module tb;
   import ddtw_pkg::*;

   // Register indexes past the last register; writes to them are ignored.
   localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
   localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

   // Cycles the block may still be busy after its last response.
   localparam int unsigned DRAIN_CYCLES = 40;
   // Length of the long response hold-off.
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned MAX_REPORTS = 10;

   typedef struct packed {
      logic [7:0] tile_x;
      logic [7:0] tile_y;
      logic [7:0] tile_index;
      logic       negative_error;
      logic       last_digit;
   } tile_write_type;

   typedef enum logic [1:0] {
      RX_STEADY,
      RX_COIN,
      RX_EVERY_THIRD,
      RX_SPARSE
   } rx_mode_type;

   // Predicts the tile writes of each request and checks the responses.
   class digit_tile_checker;
      logic [7:0] origin_x;
      logic [7:0] origin_y;
      logic [7:0] area_width;
      logic [7:0] area_height;
      logic [7:0] tile_base;
      logic [7:0] cursor;
      tile_write_type expected_writes[$];
      int unsigned mismatch_count;

      function new();
         origin_x       = '0;
         origin_y       = '0;
         area_width     = 8'd1;
         area_height    = 8'd1;
         tile_base      = '0;
         cursor         = '0;
         mismatch_count = 0;
      endfunction

      function void set_register(logic [2:0] index, logic [7:0] value);
         case (index)
            REG_ORIGIN_X:    origin_x = value;
            REG_ORIGIN_Y:    origin_y = value;
            REG_AREA_WIDTH:  area_width = value;
            REG_AREA_HEIGHT: area_height = value;
            REG_TILE_BASE:   tile_base = value;
            default: ;
         endcase
      endfunction

      // Works out the tile writes caused by one accepted request.
      function void predict_writes(logic cmd, logic signed [15:0] value);
         int unsigned magnitude;
         int unsigned divisor;
         int unsigned cols;
         int unsigned rows;
         int unsigned digit_count;
         logic [3:0] digits [5];
         tile_write_type item;

         if (cmd == CMD_CLEAR) begin
            cursor = '0;
            return;
         end
         item = '0;
         if (value < 0) begin
            item.negative_error = 1'b1;
            item.last_digit     = 1'b1;
            expected_writes.push_back(item);
            return;
         end

         // Split into decimal digits, dropping leading zeros.
         magnitude   = 32'(value);
         digit_count = 0;
         for (divisor = 10000; divisor >= 1; divisor = divisor / 10) begin
            if (magnitude / divisor != 0 || divisor == 1) begin
               digits[digit_count] = 4'((magnitude / divisor) % 10);
               digit_count++;
            end
         end

         // A zero width or height stands for 256.
         cols = (area_width == 0) ? 256 : area_width;
         rows = (area_height == 0) ? 256 : area_height;
         for (int unsigned i = 0; i < digit_count; i++) begin
            item.tile_x         = 8'(origin_x + cursor % cols);
            item.tile_y         = 8'(origin_y + (cursor / cols) % rows);
            item.tile_index     = digits[i] + tile_base;
            item.negative_error = 1'b0;
            item.last_digit     = (i + 1 == digit_count);
            expected_writes.push_back(item);
            cursor = cursor + 8'd1;
         end
      endfunction

      function void check_write(tile_write_type actual);
         tile_write_type wanted;

         if (expected_writes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("ERROR: unexpected tile write x=%0d y=%0d tile=%0d neg=%0b last=%0b",
                        actual.tile_x, actual.tile_y, actual.tile_index,
                        actual.negative_error, actual.last_digit);
            return;
         end
         wanted = expected_writes.pop_front();
         if (actual !== wanted) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display({"ERROR: tile write mismatch: expected x=%0d y=%0d tile=%0d ",
                         "neg=%0b last=%0b, got x=%0d y=%0d tile=%0d neg=%0b last=%0b"},
                        wanted.tile_x, wanted.tile_y, wanted.tile_index,
                        wanted.negative_error, wanted.last_digit,
                        actual.tile_x, actual.tile_y, actual.tile_index,
                        actual.negative_error, actual.last_digit);
         end
      endfunction

      function int unsigned pending();
         return expected_writes.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_we;
   logic [2:0] csr_index;
   logic [7:0] csr_wdata;

   int unsigned hold_request = 0;
   digit_tile_checker board = new();

   ddtw_req_if req_bus ();
   ddtw_rsp_if rsp_bus ();

   decimal_digit_tile_writer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Every accepted request transaction feeds the predictor.
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         board.predict_writes(req_bus.cmd, req_bus.number);
   end

   // Every accepted response transaction is checked.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_write({rsp_bus.tile_x, rsp_bus.tile_y, rsp_bus.tile_index,
                            rsp_bus.negative_error, rsp_bus.last_digit});
   end

   // Response side: changing stall patterns, plus a long hold-off on request.
   initial begin
      int unsigned hold_left;
      int unsigned mode_left;
      int unsigned beat;
      rx_mode_type rx_mode;

      hold_left = 0;
      mode_left = 0;
      beat      = 0;
      rx_mode   = RX_STEADY;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               rx_mode   = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            beat++;
            case (rx_mode)
               RX_STEADY:      rsp_bus.ready <= 1'b1;
               RX_COIN:        rsp_bus.ready <= ($urandom_range(0, 1) == 1);
               RX_EVERY_THIRD: rsp_bus.ready <= (beat % 3 != 0);
               default:        rsp_bus.ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // Offers one request and returns at the edge that accepts it.
   task automatic send_request(input logic cmd, input logic signed [15:0] value);
      req_bus.valid  <= 1'b1;
      req_bus.cmd    <= cmd;
      req_bus.number <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Drops valid for a number of cycles with junk on the payload.
   task automatic idle_cycles(input int unsigned count);
      req_bus.valid  <= 1'b0;
      req_bus.cmd    <= 1'($urandom_range(0, 1));
      req_bus.number <= 16'($urandom());
      repeat (count) @(posedge clock);
   endtask

   // Waits until every expected write has arrived and the block is quiet.
   task automatic settle();
      idle_cycles(1);
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      board.set_register(index, value);
      @(posedge clock);
   endtask

   task automatic configure(input logic [7:0] ox, input logic [7:0] oy,
                            input logic [7:0] cols, input logic [7:0] rows,
                            input logic [7:0] base);
      settle();
      write_register(REG_ORIGIN_X, ox);
      write_register(REG_ORIGIN_Y, oy);
      write_register(REG_AREA_WIDTH, cols);
      write_register(REG_AREA_HEIGHT, rows);
      write_register(REG_TILE_BASE, base);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly prints of a random digit count, some negatives, a few clears.
   task automatic next_random_item(output logic cmd, output logic signed [15:0] value);
      int unsigned pick;

      pick  = $urandom_range(0, 99);
      cmd   = CMD_PRINT;
      value = 16'($urandom());
      if (pick < 5) begin
         cmd = CMD_CLEAR;
      end else if (pick < 18) begin
         value = 16'h8000 | 16'($urandom_range(0, 16'h7FFF));
      end else begin
         case ($urandom_range(1, 5))
            1:       value = 16'($urandom_range(0, 9));
            2:       value = 16'($urandom_range(10, 99));
            3:       value = 16'($urandom_range(100, 999));
            4:       value = 16'($urandom_range(1000, 9999));
            default: value = 16'($urandom_range(10000, 32767));
         endcase
      end
   endtask

   // Random requests in bursts; optionally holds the response side off midway.
   task automatic run_random_items(input int unsigned count, input bit with_hold);
      int unsigned sent;
      int unsigned burst_left;
      int unsigned gap;
      logic cmd;
      logic signed [15:0] value;

      sent       = 0;
      burst_left = 0;
      while (sent < count) begin
         if (with_hold && sent == count / 2) begin
            hold_request = HOLD_CYCLES;
            burst_left   = 12;
         end
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
               idle_cycles(gap);
            burst_left = $urandom_range(1, 10);
         end
         next_random_item(cmd, value);
         send_request(cmd, value);
         sent++;
         burst_left--;
      end
   endtask

   // Stimulus.
   initial begin
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.cmd    <= CMD_PRINT;
      req_bus.number <= '0;
      csr_we         <= 1'b0;
      csr_index      <= '0;
      csr_wdata      <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: a one by one area, one, two, three and five digits, and both signs.
      send_request(CMD_PRINT, 16'sd0);
      send_request(CMD_PRINT, 16'sd9);
      send_request(CMD_PRINT, 16'sd10);
      send_request(CMD_PRINT, 16'sd99);
      send_request(CMD_PRINT, 16'sd100);
      send_request(CMD_PRINT, 16'sd10000);
      send_request(CMD_PRINT, 16'sd32767);
      send_request(CMD_PRINT, -16'sd1);
      send_request(CMD_PRINT, -16'sd32768);
      send_request(CMD_CLEAR, 16'sd12345);
      send_request(CMD_PRINT, 16'sd12345);

      // Zero width and height, everything at the top so all fields wrap.
      configure(8'd255, 8'd255, 8'd0, 8'd0, 8'd255);
      write_register(REG_SPARE_FIRST, 8'hAA);
      write_register(REG_SPARE_LAST, 8'h55);
      csr_we <= 1'b0;
      @(posedge clock);
      send_request(CMD_PRINT, 16'sd32767);
      send_request(CMD_PRINT, 16'sd9);
      send_request(CMD_CLEAR, -16'sd1);
      send_request(CMD_PRINT, 16'sd4096);

      // A 255 by 255 area with a zero base.
      configure(8'd0, 8'd0, 8'd255, 8'd255, 8'd0);
      send_request(CMD_PRINT, 16'sd22222);
      send_request(CMD_PRINT, 16'sd1);
      send_request(CMD_PRINT, 16'sd21845);

      // Random phases under different settings.
      configure(8'($urandom()), 8'($urandom()), 8'($urandom_range(1, 255)),
                8'($urandom_range(1, 255)), 8'($urandom()));
      run_random_items(23, 1'b0);
      configure(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      run_random_items(23, 1'b0);
      configure(8'($urandom()), 8'($urandom()), 8'($urandom_range(1, 4)),
                8'($urandom_range(1, 4)), 8'($urandom_range(240, 255)));
      run_random_items(23, 1'b1);
      configure(8'($urandom()), 8'($urandom()), 8'($urandom_range(0, 1)),
                8'($urandom_range(0, 6)), 8'($urandom()));
      run_random_items(23, 1'b0);

      settle();
      if (board.pending() != 0)
         $display("ERROR: %0d expected tile writes never arrived", board.pending());
      if (board.mismatch_count == 0 && board.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #5_000_000;
      $display("ERROR: timeout with %0d tile writes outstanding", board.pending());
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ddtw_pkg.sv
rtl/ddtw_if.sv
rtl/ddtw_ctrl.sv
rtl/ddtw_datapath.sv
rtl/decimal_digit_tile_writer.sv
tb/tb.sv
